/* hw/rtl/bitmap_to_run_regions_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap run-region extractor
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BITMAP_TO_RUN_REGIONS_ASSERT_SVH
`define BITMAP_TO_RUN_REGIONS_ASSERT_SVH

// condition holds on every cycle outside reset
`define BRR_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// antecedent implies consequent on the following cycle, outside reset
`define BRR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// condition holds on the cycle after reset is sampled
`define BRR_ASSERT_AFTER_RESET(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) !(rstn) |=> (cond)) \
        else $error(msg);

`endif

/* hw/rtl/brr_pkg.sv */
// ---------------------------------------------------------------------------
// brr_pkg
// Widths, register indexes and shared types of the bitmap run-region extractor.
// ---------------------------------------------------------------------------
package brr_pkg;

    localparam int PAGE_BITS     = 36;
    localparam int OFFSET_BITS   = 48;
    localparam int CNT_BITS      = PAGE_BITS - 3;
    localparam int ESIZE_BITS    = 21;
    localparam int PROD_BITS     = PAGE_BITS + ESIZE_BITS;
    localparam int CFG_DATA_BITS = 48;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_MSB_FIRST    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_SIZE = 3'd4;

    localparam logic [ESIZE_BITS-1:0] ESIZE_RESET = 21'd4096;

    typedef struct packed {
        logic                  msb_first;
        logic [PAGE_BITS-1:0]  window_start;
        logic [PAGE_BITS-1:0]  window_end;
        logic [ESIZE_BITS-1:0] element_size;
    } cfg_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] start;
        logic [PAGE_BITS-1:0] count;
        logic                 last;
    } region_t;

endpackage

/* hw/rtl/brr_scan.sv */
// ---------------------------------------------------------------------------
// brr_scan
// Holds one bitmap byte, finds the runs that close in it and hands them out
// one per cycle while r_ready is high; keeps the open-run state and the byte counter.
// ---------------------------------------------------------------------------
module brr_scan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  brr_pkg::cfg_t                       cfg,
    input  logic                                restart,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_bitmap_byte,
    output logic                                r_valid,
    input  logic                                r_ready,
    output brr_pkg::region_t                    r_region
);
    import brr_pkg::*;

    function automatic logic [2:0] low_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [2:0] high_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    logic [7:0]           byte_reg;
    logic [CNT_BITS-1:0]  base_reg;
    logic                 valid_reg;
    logic [7:0]           done_reg;
    logic [CNT_BITS-1:0]  counter_reg;
    logic                 in_run_reg;
    logic [PAGE_BITS-1:0] run_begin_reg;

    logic [7:0]           bits;
    logic [7:0]           above_start;
    logic [7:0]           below_end;
    logic [7:0]           live;
    logic [7:0]           prev;
    logic [7:0]           fall;
    logic [7:0]           rise;
    logic [7:0]           pend;
    logic [2:0]           end_idx;
    logic [7:0]           early_mask;
    logic [7:0]           early_rise;
    logic [2:0]           begin_idx;
    logic [PAGE_BITS-1:0] begin_page;
    logic [PAGE_BITS-1:0] end_page;
    logic                 last;
    logic                 emit;
    logic                 retire;
    logic                 in_run_next;
    logic [PAGE_BITS-1:0] run_begin_next;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            bits[i] = cfg.msb_first ? byte_reg[7-i] : byte_reg[i];
            above_start[i] = (base_reg > cfg.window_start[PAGE_BITS-1:3]) ||
                             ((base_reg == cfg.window_start[PAGE_BITS-1:3]) &&
                              (3'(i) >= cfg.window_start[2:0]));
            below_end[i]   = (base_reg < cfg.window_end[PAGE_BITS-1:3]) ||
                             ((base_reg == cfg.window_end[PAGE_BITS-1:3]) &&
                              (3'(i) < cfg.window_end[2:0]));
        end
    end

    assign live = bits & above_start & below_end;
    assign prev = {live[6:0], in_run_reg};
    assign fall = ~live & prev;
    assign rise = live & ~prev;
    assign pend = fall & ~done_reg;

    assign end_idx    = low_index(pend);
    assign early_mask = (8'd1 << end_idx) - 8'd1;
    assign early_rise = rise & early_mask;
    assign begin_idx  = high_index(early_rise);
    assign begin_page = (|early_rise) ? {base_reg, begin_idx} : run_begin_reg;
    assign end_page   = {base_reg, end_idx};
    assign last       = (pend & (pend - 8'd1)) == 8'd0;

    assign r_valid         = valid_reg && (|pend);
    assign r_region.start  = begin_page;
    assign r_region.count  = end_page - begin_page;
    assign r_region.last   = last;

    assign emit    = r_valid && r_ready;
    assign retire  = valid_reg && (!(|pend) || (r_ready && last));
    assign s_ready = !valid_reg || retire;

    assign in_run_next    = live[7];
    assign run_begin_next = (|rise) ? {base_reg, high_index(rise)} : run_begin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            done_reg      <= '0;
            counter_reg   <= '0;
            in_run_reg    <= 1'b0;
            run_begin_reg <= '0;
        end else if (restart) begin
            counter_reg   <= '0;
            in_run_reg    <= 1'b0;
            run_begin_reg <= '0;
        end else begin
            if (retire) begin
                in_run_reg    <= in_run_next;
                run_begin_reg <= run_begin_next;
            end
            if (s_valid && s_ready) begin
                valid_reg   <= 1'b1;
                done_reg    <= '0;
                counter_reg <= counter_reg + 1'b1;
            end else if (retire) begin
                valid_reg <= 1'b0;
            end else if (emit) begin
                done_reg <= done_reg | (8'd1 << end_idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_bitmap_byte;
            base_reg <= counter_reg;
        end
    end

endmodule

/* hw/rtl/brr_emit.sv */
// ---------------------------------------------------------------------------
// brr_emit
// Region pipeline: capture, size product, then file offset assignment into
// the result register.
// ---------------------------------------------------------------------------
module brr_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [brr_pkg::ESIZE_BITS-1:0]      element_size,
    input  logic                                restart,
    input  logic [brr_pkg::OFFSET_BITS-1:0]     base_offset,
    input  logic                                r_valid,
    output logic                                r_ready,
    input  brr_pkg::region_t                    r_region,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [brr_pkg::PAGE_BITS-1:0]       m_region_start,
    output logic [brr_pkg::PAGE_BITS-1:0]       m_region_count,
    output logic [brr_pkg::OFFSET_BITS-1:0]     m_region_offset,
    output logic                                m_last_of_item
);
    import brr_pkg::*;

    logic                   a_valid_reg;
    region_t                a_reg;
    logic                   b_valid_reg;
    region_t                b_reg;
    logic [OFFSET_BITS-1:0] prod_reg;
    logic                   out_valid_reg;
    region_t                out_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [OFFSET_BITS-1:0] acc_reg;

    logic                   out_ready;
    logic                   b_ready;
    logic [PROD_BITS-1:0]   prod_full;

    assign out_ready = !out_valid_reg || m_ready;
    assign b_ready   = !b_valid_reg || out_ready;
    assign r_ready   = !a_valid_reg || b_ready;

    assign prod_full = PROD_BITS'(a_reg.count) * PROD_BITS'(element_size);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end else begin
            if (r_ready) begin
                a_valid_reg <= r_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= b_valid_reg;
            end
            if (restart) begin
                acc_reg <= base_offset;
            end else if (out_ready && b_valid_reg) begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready && r_valid) begin
            a_reg <= r_region;
        end
        if (b_ready && a_valid_reg) begin
            b_reg    <= a_reg;
            prod_reg <= prod_full[OFFSET_BITS-1:0];
        end
        if (out_ready && b_valid_reg) begin
            out_reg        <= b_reg;
            out_offset_reg <= acc_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_region_start  = out_reg.start;
    assign m_region_count  = out_reg.count;
    assign m_region_offset = out_offset_reg;
    assign m_last_of_item  = out_reg.last;

endmodule

/* hw/rtl/bitmap_to_run_regions.sv */
// The first region of a byte passes the byte, capture, product and result registers in turn.
// Throughput: one byte per cycle unless stalled or a byte closes more than one run (at most 4).
// The scan register serializes closed runs; the offset adder updates once per region.
// Reset (aresetn, synchronous, active low) clears all control state and the
// configuration (element size back to 4096); no clearing pass is needed.
// ---------------------------------------------------------------------------
// bitmap_to_run_regions
// Turns a byte stream of a page bitmap into runs of set pages inside a
// window, each with its page start, length and file offset.
// ---------------------------------------------------------------------------
module bitmap_to_run_regions (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [brr_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
    input  logic [brr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_bitmap_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [brr_pkg::PAGE_BITS-1:0]       m_region_start,
    output logic [brr_pkg::PAGE_BITS-1:0]       m_region_count,
    output logic [brr_pkg::OFFSET_BITS-1:0]     m_region_offset,
    output logic                                m_last_of_item
);
    import brr_pkg::*;

    cfg_t    cfg_reg;
    logic    restart;
    logic    r_valid;
    logic    r_ready;
    region_t r_region;

    assign restart = cfg_wen && (cfg_addr == REG_BASE_OFFSET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.msb_first    <= 1'b0;
            cfg_reg.window_start <= '0;
            cfg_reg.window_end   <= '0;
            cfg_reg.element_size <= ESIZE_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_MSB_FIRST: begin
                    cfg_reg.msb_first <= cfg_wdata[0];
                end
                REG_WINDOW_START: begin
                    cfg_reg.window_start <= cfg_wdata[PAGE_BITS-1:0];
                end
                REG_WINDOW_END: begin
                    cfg_reg.window_end <= cfg_wdata[PAGE_BITS-1:0];
                end
                REG_ELEMENT_SIZE: begin
                    cfg_reg.element_size <= cfg_wdata[ESIZE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    brr_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .restart       (restart),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_bitmap_byte (s_bitmap_byte),
        .r_valid       (r_valid),
        .r_ready       (r_ready),
        .r_region      (r_region)
    );

    brr_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .element_size    (cfg_reg.element_size),
        .restart         (restart),
        .base_offset     (cfg_wdata[OFFSET_BITS-1:0]),
        .r_valid         (r_valid),
        .r_ready         (r_ready),
        .r_region        (r_region),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_region_start  (m_region_start),
        .m_region_count  (m_region_count),
        .m_region_offset (m_region_offset),
        .m_last_of_item  (m_last_of_item)
    );

endmodule

/* hw/rtl/brr_checker.sv */
// ---------------------------------------------------------------------------
// brr_checker
// Port-level checks of the region result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "bitmap_to_run_regions_assert.svh"

module brr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [brr_pkg::PAGE_BITS-1:0]       m_region_start,
    input logic [brr_pkg::PAGE_BITS-1:0]       m_region_count,
    input logic [brr_pkg::OFFSET_BITS-1:0]     m_region_offset,
    input logic                                m_last_of_item
);

    // hold a stalled transaction
    `BRR_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_region_start) && $stable(m_region_count) && $stable(m_region_offset) && $stable(m_last_of_item), "stalled result changed")

    `BRR_ASSERT_ALWAYS(a_count_nonzero, aclk, aresetn, !m_valid || (m_region_count != '0), "empty region")

    // regions of one byte follow back to back
    `BRR_ASSERT_NEXT(a_item_contiguous, aclk, aresetn, m_valid && m_ready && !m_last_of_item, m_valid, "gap inside the regions of one byte")

    `BRR_ASSERT_AFTER_RESET(a_reset_idle, aclk, aresetn, !m_valid, "result valid after reset")

endmodule

bind bitmap_to_run_regions brr_checker u_brr_checker (.*);
